// ===== src/hamming_secded_codec_top_assert.svh =====
// Assertion macros used by the codec top level
`ifndef HAMMING_SECDED_CODEC_TOP_ASSERT_SVH
`define HAMMING_SECDED_CODEC_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define HSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/hsc_pkg.sv =====
// Package: word types, codes and position helpers for the SECDED codec
`default_nettype none

package hsc_pkg;

	localparam int DATA_W   = 32;
	localparam int CHECK_W  = 7;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_CHECK  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CORRECTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DOUBLE    = 2'd2;

	typedef struct packed {
		logic               operation;
		logic [DATA_W-1:0]  data_in;
		logic [CHECK_W-1:0] check_in;
	} hsc_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]   data_out;
		logic [CHECK_W-1:0]  check_out;
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    error_position;
	} hsc_rsp_t;

	// codeword position of data bit k: the (k+1)-th non power of two above 2
	function automatic logic [POS_W-1:0] data_pos(input int k);
		int pos;
		pos = 2;
		for (int i = 0; i <= k; i++) begin
			pos = pos + 1;
			if ((pos & (pos - 1)) == 0) begin
				pos = pos + 1;
			end
		end
		return POS_W'(pos);
	endfunction

	function automatic logic [DATA_W-1:0] data_mask(input int n);
		logic [DATA_W-1:0] m;
		for (int i = 0; i < DATA_W; i++) begin
			m[i] = (i < n);
		end
		return m;
	endfunction

	function automatic logic [CHECK_W-1:0] check_mask(input int n);
		logic [CHECK_W-1:0] m;
		for (int i = 0; i < CHECK_W; i++) begin
			m[i] = (i < n);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== src/hamming_secded_codec_top.sv =====
// Top level: input register, SECDED codec, result register
//
//   channel | valid     | ready     | word
//   --------+-----------+-----------+-------------------
//   request | req_valid | req_ready | req (hsc_req_t)
//   result  | rsp_valid | rsp_ready | rsp (hsc_rsp_t)
//
// One word per cycle while rsp_ready is high; the result register drives rsp.
// The codec sits between the input register and the result register.
// Reset clears both stage valids; payload registers are not reset.
// A stalled result holds in its register while the input stage still fills,
// so two words are held before req_ready drops.
`default_nettype none

module hamming_secded_codec_top
	import hsc_pkg::*;
#(
	parameter int DATA_BITS  = 32,
	parameter int CHECK_BITS = 7
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire hsc_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output hsc_rsp_t      rsp
);

	localparam logic [DATA_W-1:0]  DMASK = data_mask(DATA_BITS);
	localparam logic [CHECK_W-1:0] CMASK = check_mask(CHECK_BITS);

	hsc_req_t req_s1;
	logic     valid_s1;
	hsc_rsp_t rsp_s2;
	logic     valid_s2;
	hsc_rsp_t res;
	logic     ready_s1;
	logic     ready_s2;

	assign ready_s2  = !valid_s2 || rsp_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign req_ready = ready_s1;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	hsc_codec #(
		.DATA_BITS  (DATA_BITS),
		.CHECK_BITS (CHECK_BITS)
	) u_codec (
		.req (req_s1),
		.rsp (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= req_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && ready_s1) begin
			req_s1 <= req;
		end
		if (valid_s1 && ready_s2) begin
			rsp_s2 <= res;
		end
	end

`include "hamming_secded_codec_top_assert.svh"

	`HSC_ASSERT_NXT(a_s1_hold,
		valid_s1 && !ready_s2,
		valid_s1 && $stable(req_s1),
		"input stage lost a word while stalled")
	`HSC_ASSERT_IMP(a_enc_clean,
		valid_s1 && req_s1.operation == OP_ENCODE,
		res.status == STATUS_OK && res.error_position == '0
			&& res.data_out == (req_s1.data_in & DMASK),
		"encode altered data or flagged an error")
	`HSC_ASSERT_IMP(a_fix_one_bit,
		valid_s1 && req_s1.operation == OP_CHECK && res.status == STATUS_CORRECTED,
		$onehot({res.data_out ^ (req_s1.data_in & DMASK),
			res.check_out ^ (req_s1.check_in & CMASK)}),
		"correction did not flip exactly one bit")
	`HSC_ASSERT_IMP(a_no_fix_else,
		valid_s1 && req_s1.operation == OP_CHECK && res.status != STATUS_CORRECTED,
		res.data_out == (req_s1.data_in & DMASK)
			&& res.check_out == (req_s1.check_in & CMASK),
		"word changed without a correction")

endmodule

`default_nettype wire

// ===== src/hsc_codec.sv =====
// Combinational SECDED encode and check/correct of one word
`default_nettype none

module hsc_codec
	import hsc_pkg::*;
#(
	parameter int DATA_BITS  = 32,
	parameter int CHECK_BITS = 7
) (
	input  wire hsc_req_t req,
	output hsc_rsp_t      rsp
);

	localparam int HAM_BITS = CHECK_BITS - 1;
	localparam logic [DATA_W-1:0]  DMASK = data_mask(DATA_BITS);
	localparam logic [CHECK_W-1:0] CMASK = check_mask(CHECK_BITS);
	localparam logic [CHECK_W-1:0] HMASK = check_mask(HAM_BITS);

	logic [DATA_W-1:0]  data_m;
	logic [CHECK_W-1:0] chk_m;
	logic [POS_W-1:0]   dsyn;
	logic [POS_W-1:0]   syn;
	logic [DATA_W-1:0]  hit;
	logic               par;
	logic               all_par;
	logic               syn_pow2;
	logic [CHECK_W-1:0] top_bit;

	assign data_m  = req.data_in & DMASK;
	assign chk_m   = req.check_in & CMASK;
	assign top_bit = CHECK_W'(1) << HAM_BITS;

	always_comb begin
		dsyn = '0;
		for (int k = 0; k < DATA_W; k++) begin
			if (data_m[k]) begin
				dsyn = dsyn ^ data_pos(k);
			end
		end
		dsyn = dsyn & HMASK[POS_W-1:0];
	end

	assign syn      = (chk_m[POS_W-1:0] & HMASK[POS_W-1:0]) ^ dsyn;
	assign par      = (^data_m) ^ (^chk_m);
	assign all_par  = (^data_m) ^ (^dsyn);
	assign syn_pow2 = (syn != '0) && ((syn & (syn - 1'b1)) == '0);

	always_comb begin
		for (int k = 0; k < DATA_W; k++) begin
			hit[k] = DMASK[k] && (data_pos(k) == syn);
		end
	end

	always_comb begin
		rsp.data_out       = data_m;
		rsp.check_out      = chk_m;
		rsp.status         = STATUS_OK;
		rsp.error_position = '0;
		if (req.operation == OP_ENCODE) begin
			rsp.check_out = (({1'b0, dsyn}) | (all_par ? top_bit : '0)) & CMASK;
		end else begin
			rsp.error_position = syn;
			priority if (syn == '0) begin
				if (par) begin
					rsp.check_out = chk_m ^ top_bit;
					rsp.status    = STATUS_CORRECTED;
				end
			end else if (!par) begin
				rsp.status = STATUS_DOUBLE;
			end else if (syn_pow2) begin
				rsp.check_out = chk_m ^ {1'b0, syn};
				rsp.status    = STATUS_CORRECTED;
			end else if (hit != '0) begin
				rsp.data_out = data_m ^ hit;
				rsp.status   = STATUS_CORRECTED;
			end else begin
				rsp.status = STATUS_DOUBLE;
			end
		end
	end

endmodule

`default_nettype wire
